FILE: sv/fogu_pkg.sv
`default_nettype none

package fogu_pkg;

  // Depth of the coefficient store and the delay line.
  localparam int unsigned MAX_TAPS_DEF = 256;

  // Field widths of the stream and configuration ports.
  localparam int unsigned TAP_INDEX_W  = 8;
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned COEF_W       = 16;
  localparam int unsigned GAIN_W       = 16;
  localparam int unsigned TAP_COUNT_W  = 9;
  localparam int unsigned IN_TDATA_W   = 40;
  localparam int unsigned OUT_TDATA_W  = 16;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned PROD_W       = 32;

  // Configuration register indexes.
  localparam logic CFG_TAP_COUNT   = 1'b0;
  localparam logic CFG_OUTPUT_GAIN = 1'b1;

  // Request kinds carried in in_tuser.
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // Saturated output codes.
  localparam logic [OUT_TDATA_W-1:0] SAT_POS = 16'h7fff;
  localparam logic [OUT_TDATA_W-1:0] SAT_NEG = 16'h8000;

endpackage

`default_nettype wire

FILE: sv/fir_filter_with_output_gain_unit.sv
`default_nettype none

// Channel | Direction | Payload (lowest bit first)
// in_     | slave     | tuser: req_type; tdata: tap_index, coef_value, sample_in
// out_    | master    | tuser: clipped;  tdata: sample_out
// cfg_    | write     | cfg_index selects tap_count or output_gain, cfg_wdata the value
//
// A load beat does not hold the input side: the coefficient is written in the cycle it is accepted.
// A sample beat holds the input side from its accepting edge to the next edge that can take
// a beat, and its result shows on out_tvalid at that edge. The multiply-accumulate walks
// the coefficient store and the delay line one tap per cycle for tap_count taps (saturated
// to MAX_TAPS), so the single read port of each memory sets the pace of the walk.
// Reset (rst_n, synchronous, active low) needs no sweep: a fill count marks which delay
// line entries were ever written, and unwritten entries read as zero.
// The result sits in an output register, so new beats are taken while it waits; only
// when a second result is ready before the first one is taken does the block stall.
module fir_filter_with_output_gain_unit
  import fogu_pkg::*;
#(
  parameter int unsigned MAX_TAPS = MAX_TAPS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Configuration write port.
  input  wire logic                   cfg_wr_en,
  input  wire logic                   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  // Input stream.
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // tap_index[7:0], coef_value[23:8],
                                                  // sample_in[39:24]
  input  wire logic                   in_tuser,   // req_type
  // Result stream.
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // sample_out[15:0]
  output logic                        out_tuser   // clipped
);

  localparam int unsigned AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned TW    = AW + 1;
  // A sum of up to 2^AW products, each of magnitude at most 2^30.
  localparam int unsigned ACC_W = PROD_W + AW;
  localparam int unsigned HW    = ACC_W - 16;
  localparam int unsigned PH_W  = HW + GAIN_W + 1;
  localparam int unsigned SW    = ACC_W + GAIN_W + 2;
  localparam int unsigned YW    = SW - 30;

  localparam logic signed [SW-1:0] RND_C = SW'(32'h2000_0000);
  localparam logic signed [YW-1:0] Y_MAX = YW'(32767);
  localparam logic signed [YW-1:0] Y_MIN = YW'(-32768);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MAC  = 2'd1;
  localparam logic [1:0] S_GAIN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  // Input field unpacking.
  logic [TAP_INDEX_W-1:0]   in_tap_index;
  logic signed [COEF_W-1:0] in_coef_value;
  logic signed [SAMPLE_W-1:0] in_sample;

  assign in_tap_index  = in_tdata[7:0];
  assign in_coef_value = $signed(in_tdata[23:8]);
  assign in_sample     = $signed(in_tdata[39:24]);

  // Configuration registers.
  logic [TAP_COUNT_W-1:0] tap_count_r;
  logic [GAIN_W-1:0]      gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAP_COUNT_W'(1);
      gain_r      <= GAIN_W'(32768);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_TAP_COUNT:   tap_count_r <= cfg_wdata[TAP_COUNT_W-1:0];
        CFG_OUTPUT_GAIN: gain_r      <= cfg_wdata[GAIN_W-1:0];
      endcase
    end
  end

  // Sequencer state and pointers.
  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] wp_r;      // next delay line slot to write
  logic [TW-1:0] fill_r;    // number of delay line slots ever written
  logic [AW-1:0] rp_r;      // delay line read address, walks backward
  logic [TW-1:0] k_r;       // tap being issued
  logic [TW-1:0] taps_r;    // taps in use for the current sample

  logic          rd_v_r;    // memory read data valid
  logic          dl_ok_r;   // delay line entry read was written before
  logic          pr_v_r;    // product register valid
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [31:0]              pp_lo_r;
  logic signed [PH_W-1:0]   pp_hi_r;

  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_clip_r;
  logic                   out_valid_r;

  logic in_acc, is_sample, issue, mac_done, out_free, idx_ok;
  logic [TW-1:0] taps_sat;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign is_sample = (in_tuser == REQ_SAMPLE);
  assign idx_ok    = (32'(in_tap_index) < MAX_TAPS);
  assign taps_sat  = (32'(tap_count_r) > MAX_TAPS) ? TW'(MAX_TAPS) : TW'(tap_count_r);
  assign issue     = (state_r == S_MAC) && (k_r < taps_r);
  assign mac_done  = (state_r == S_MAC) && !issue && !rd_v_r && !pr_v_r;
  assign out_free  = !out_valid_r || out_tready;

  // Coefficient store: written by load beats, read one tap per cycle.
  logic signed [COEF_W-1:0] coef_mem [MAX_TAPS];
  logic signed [COEF_W-1:0] coef_rd_r;

  always_ff @(posedge clk) begin
    if (in_acc && !is_sample && idx_ok) begin
      coef_mem[AW'(in_tap_index)] <= in_coef_value;
    end
    coef_rd_r <= coef_mem[k_r[AW-1:0]];
  end

  // Delay line: a circular buffer written at wp_r, read backward from the newest sample.
  logic signed [SAMPLE_W-1:0] dl_mem [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] dl_rd_r;

  always_ff @(posedge clk) begin
    if (in_acc && is_sample) begin
      dl_mem[wp_r] <= in_sample;
    end
    dl_rd_r <= dl_mem[rp_r];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc && is_sample) state_nxt = S_MAC;
      S_MAC:  if (mac_done) state_nxt = S_GAIN;
      S_GAIN: state_nxt = S_FIN;
      S_FIN:  if (out_free) state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wp_r    <= '0;
      fill_r  <= '0;
      rp_r    <= '0;
      k_r     <= '0;
      taps_r  <= '0;
      rd_v_r  <= 1'b0;
      pr_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= issue;
      pr_v_r  <= rd_v_r;
      if (in_acc && is_sample) begin
        k_r    <= '0;
        rp_r   <= wp_r;
        taps_r <= taps_sat;
        wp_r   <= (32'(wp_r) == MAX_TAPS - 1) ? '0 : wp_r + 1'b1;
        if (32'(fill_r) < MAX_TAPS) begin
          fill_r <= fill_r + 1'b1;
        end
      end else if (issue) begin
        k_r  <= k_r + 1'b1;
        rp_r <= (rp_r == '0) ? AW'(MAX_TAPS - 1) : rp_r - 1'b1;
      end
    end
  end

  // Datapath: read, multiply, accumulate, then scale by the gain in two partial products.
  always_ff @(posedge clk) begin
    dl_ok_r <= ({1'b0, rp_r} < fill_r);
    prod_r  <= coef_rd_r * (dl_ok_r ? dl_rd_r : SAMPLE_W'(0));
    if (in_acc && is_sample) begin
      acc_r <= '0;
    end else if (pr_v_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (state_r == S_GAIN) begin
      pp_lo_r <= acc_r[15:0] * gain_r;
      pp_hi_r <= $signed(acc_r[ACC_W-1:16]) * $signed({1'b0, gain_r});
    end
  end

  // Recombine, round half up to Q1.15 and saturate.
  logic signed [SW-1:0] sum_w;
  logic signed [YW-1:0] y_w;
  logic [OUT_TDATA_W-1:0] res_data;
  logic                   res_clip;

  always_comb begin
    sum_w = (SW'(pp_hi_r) <<< 16) + SW'($signed({1'b0, pp_lo_r})) + RND_C;
    y_w   = $signed(sum_w[SW-1:30]);
    if (y_w > Y_MAX) begin
      res_data = SAT_POS;
      res_clip = 1'b1;
    end else if (y_w < Y_MIN) begin
      res_data = SAT_NEG;
      res_clip = 1'b1;
    end else begin
      res_data = y_w[OUT_TDATA_W-1:0];
      res_clip = 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      out_data_r <= res_data;
      out_clip_r <= res_clip;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_clip_r;

endmodule

`default_nettype wire

FILE: sv/fogu_checker.sv
`default_nettype none

module fogu_checker
  import fogu_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   in_tuser,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tuser
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat shown right after reset");

  // A sample beat occupies the block, so no beat is taken in the next cycle.
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == REQ_SAMPLE |=> !in_tready)
    else $error("input taken while a sample is in flight");

  // A load beat finishes in its own cycle.
  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == REQ_LOAD |=> in_tready)
    else $error("load beat held the input side");

  // The clip flag only comes with a rail value.
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == SAT_POS || out_tdata == SAT_NEG)
    else $error("clip flag set on an unsaturated result");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

endmodule

bind fir_filter_with_output_gain_unit fogu_checker u_fogu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
